[src/sspsh_pkg.sv]
// Package with widths, register map and shape codes for the scanline shape pixel shader.
package sspsh_pkg;

  localparam int COLUMN_BITS = 10;
  localparam int COORD_BITS  = 12;
  localparam int SIZE_BITS   = 11;
  localparam int THICK_BITS  = 8;
  localparam int COLOR_BITS  = 16;
  localparam int KIND_BITS   = 2;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;
  localparam int IN_BITS     = 48;
  localparam int OUT_BITS    = 24;

  // Working width for positions, sums and differences of coordinates.
  localparam int POS_BITS    = 14;
  localparam int SQ_BITS     = 27;
  localparam int RAD_BITS    = 10;
  localparam int DIA_BITS    = 11;
  localparam int THR_BITS    = 22;

  localparam logic [2:0] REG_SHAPE_KIND     = 3'd0;
  localparam logic [2:0] REG_BOX_LEFT       = 3'd1;
  localparam logic [2:0] REG_BOX_TOP        = 3'd2;
  localparam logic [2:0] REG_BOX_WIDTH      = 3'd3;
  localparam logic [2:0] REG_BOX_HEIGHT     = 3'd4;
  localparam logic [2:0] REG_EDGE_THICKNESS = 3'd5;
  localparam logic [2:0] REG_INSIDE_COLOR   = 3'd6;
  localparam logic [2:0] REG_EDGE_COLOR     = 3'd7;

  localparam logic [KIND_BITS-1:0] SHAPE_NONE   = 2'd0;
  localparam logic [KIND_BITS-1:0] SHAPE_RECT   = 2'd1;
  localparam logic [KIND_BITS-1:0] SHAPE_CIRCLE = 2'd2;

endpackage

[src/scanline_shape_pixel_shader_core.sv]
// Top level of the scanline shape pixel shader: register file and four-stage pixel pipeline.
//
//  channel  direction  ports                        word
//  in_      slave      in_tvalid/in_tready/in_tdata  column, origin, limit, row
//  out_     master     out_tvalid/out_tready/out_tdata  write enable, colour
//  cfg_     APB slave  psel/penable/pwrite/paddr/..  one register per 4-byte address
//
// One word is accepted per cycle unless a stall at the output has filled the stages;
// each result passes in turn through the four register stages: input, box tests,
// squaring, compare.
// Every stage has its own valid bit and is refilled as soon as it empties, so a stall
// at the output back-pressures stage by stage and nothing is lost or repeated.
// rst_n is synchronous and clears the valid bits and all configuration registers.
// Derived box limits and circle thresholds are registered in the cycle after a write.
module scanline_shape_pixel_shader_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pixel_column [9:0], window_origin [19:10], window_limit [29:20], line_row [41:30]
  input  logic [sspsh_pkg::IN_BITS-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // write_enable [0], pixel_color [16:1]
  output logic [sspsh_pkg::OUT_BITS-1:0]  out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sspsh_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [sspsh_pkg::DATA_BITS-1:0] cfg_pwdata,
  output logic [sspsh_pkg::DATA_BITS-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import sspsh_pkg::*;

  // Configuration registers.
  logic [KIND_BITS-1:0]         kind_r;
  logic signed [COORD_BITS-1:0] left_r;
  logic signed [COORD_BITS-1:0] top_r;
  logic [SIZE_BITS-1:0]         width_r;
  logic [SIZE_BITS-1:0]         height_r;
  logic [THICK_BITS-1:0]        thick_r;
  logic [COLOR_BITS-1:0]        inside_color_r;
  logic [COLOR_BITS-1:0]        edge_color_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[ADDR_BITS-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r         <= SHAPE_NONE;
      left_r         <= '0;
      top_r          <= '0;
      width_r        <= '0;
      height_r       <= '0;
      thick_r        <= '0;
      inside_color_r <= '0;
      edge_color_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHAPE_KIND:     kind_r         <= cfg_pwdata[KIND_BITS-1:0];
        REG_BOX_LEFT:       left_r         <= cfg_pwdata[COORD_BITS-1:0];
        REG_BOX_TOP:        top_r          <= cfg_pwdata[COORD_BITS-1:0];
        REG_BOX_WIDTH:      width_r        <= cfg_pwdata[SIZE_BITS-1:0];
        REG_BOX_HEIGHT:     height_r       <= cfg_pwdata[SIZE_BITS-1:0];
        REG_EDGE_THICKNESS: thick_r        <= cfg_pwdata[THICK_BITS-1:0];
        REG_INSIDE_COLOR:   inside_color_r <= cfg_pwdata[COLOR_BITS-1:0];
        REG_EDGE_COLOR:     edge_color_r   <= cfg_pwdata[COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHAPE_KIND:     cfg_prdata = {{(DATA_BITS-KIND_BITS){1'b0}}, kind_r};
      REG_BOX_LEFT:       cfg_prdata = {{(DATA_BITS-COORD_BITS){1'b0}}, left_r};
      REG_BOX_TOP:        cfg_prdata = {{(DATA_BITS-COORD_BITS){1'b0}}, top_r};
      REG_BOX_WIDTH:      cfg_prdata = {{(DATA_BITS-SIZE_BITS){1'b0}}, width_r};
      REG_BOX_HEIGHT:     cfg_prdata = {{(DATA_BITS-SIZE_BITS){1'b0}}, height_r};
      REG_EDGE_THICKNESS: cfg_prdata = {{(DATA_BITS-THICK_BITS){1'b0}}, thick_r};
      REG_INSIDE_COLOR:   cfg_prdata = {{(DATA_BITS-COLOR_BITS){1'b0}}, inside_color_r};
      REG_EDGE_COLOR:     cfg_prdata = {{(DATA_BITS-COLOR_BITS){1'b0}}, edge_color_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // Derived box limits and circle thresholds, refreshed every cycle.
  logic signed [POS_BITS-1:0] left_e, top_e, width_e, height_e, thick_e;
  logic signed [POS_BITS-1:0] right_r, bottom_r, left_in_r, top_in_r, right_in_r, bottom_in_r;
  logic signed [POS_BITS-1:0] cx_r, cy_r;
  logic [RAD_BITS-1:0]        radius;
  logic signed [DIA_BITS-1:0] inner_rad;
  logic [DIA_BITS-1:0]        inner_dia, outer_dia;
  logic [THR_BITS-1:0]        thr_in_r, thr_out_r;
  logic                       in_ok_r, out_ok_r;

  assign left_e   = {{(POS_BITS-COORD_BITS){left_r[COORD_BITS-1]}}, left_r};
  assign top_e    = {{(POS_BITS-COORD_BITS){top_r[COORD_BITS-1]}}, top_r};
  assign width_e  = {{(POS_BITS-SIZE_BITS){1'b0}}, width_r};
  assign height_e = {{(POS_BITS-SIZE_BITS){1'b0}}, height_r};
  assign thick_e  = {{(POS_BITS-THICK_BITS){1'b0}}, thick_r};

  assign radius    = (width_r[SIZE_BITS-1:1] < height_r[SIZE_BITS-1:1]) ?
                     width_r[SIZE_BITS-1:1] : height_r[SIZE_BITS-1:1];
  assign inner_rad = $signed({1'b0, radius}) - $signed({{(DIA_BITS-THICK_BITS){1'b0}}, thick_r});
  // Radii in half-pixel units, less one: the rounding boundary of each zone.
  assign inner_dia = {inner_rad[RAD_BITS-1:0], 1'b0} - DIA_BITS'(1);
  assign outer_dia = {radius, 1'b0} - DIA_BITS'(1);

  always_ff @(posedge clk) begin
    right_r     <= left_e + width_e;
    bottom_r    <= top_e + height_e;
    left_in_r   <= left_e + thick_e;
    top_in_r    <= top_e + thick_e;
    right_in_r  <= left_e + width_e - thick_e;
    bottom_in_r <= top_e + height_e - thick_e;
    cx_r        <= left_e + (width_e >>> 1);
    cy_r        <= top_e + (height_e >>> 1);
    in_ok_r     <= (inner_rad > 0);
    out_ok_r    <= (radius != '0);
    thr_in_r    <= THR_BITS'(inner_dia) * THR_BITS'(inner_dia);
    thr_out_r   <= THR_BITS'(outer_dia) * THR_BITS'(outer_dia);
  end

  // Stage ready chain: a stage loads when it is empty or its word moves on.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: widget x coordinate and window test.
  logic [COLUMN_BITS-1:0]        col, org, lim;
  logic signed [COLUMN_BITS:0]   x_s1_r;
  logic signed [COORD_BITS-1:0]  row_s1_r;
  logic                          win_s1_r;

  assign col = in_tdata[COLUMN_BITS-1:0];
  assign org = in_tdata[2*COLUMN_BITS-1:COLUMN_BITS];
  assign lim = in_tdata[3*COLUMN_BITS-1:2*COLUMN_BITS];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      x_s1_r   <= $signed({1'b0, col}) - $signed({1'b0, org});
      row_s1_r <= in_tdata[3*COLUMN_BITS+COORD_BITS-1:3*COLUMN_BITS];
      win_s1_r <= (col >= org) && (col <= lim);
    end
  end

  // Stage 2: box and border tests, offsets from the circle centre.
  logic signed [POS_BITS-1:0] x_e, row_e;
  logic                       cand_s2_r, border_s2_r;
  logic signed [POS_BITS-1:0] dx_s2_r, dy_s2_r;

  assign x_e   = {{(POS_BITS-COLUMN_BITS-1){x_s1_r[COLUMN_BITS]}}, x_s1_r};
  assign row_e = {{(POS_BITS-COORD_BITS){row_s1_r[COORD_BITS-1]}}, row_s1_r};

  always_ff @(posedge clk) begin
    if (rdy2) begin
      cand_s2_r   <= win_s1_r && (x_e >= left_e) && (x_e <= right_r) &&
                     (row_e >= top_e) && (row_e <= bottom_r);
      border_s2_r <= (x_e < left_in_r) || (x_e > right_in_r) ||
                     (row_e < top_in_r) || (row_e > bottom_in_r);
      dx_s2_r     <= x_e - cx_r;
      dy_s2_r     <= row_e - cy_r;
    end
  end

  // Stage 3: squared offsets.
  logic signed [2*POS_BITS-1:0] dx_sq, dy_sq;
  logic [SQ_BITS-1:0]           dx2_s3_r, dy2_s3_r;
  logic                         cand_s3_r, border_s3_r;

  assign dx_sq = (2*POS_BITS)'(dx_s2_r) * (2*POS_BITS)'(dx_s2_r);
  assign dy_sq = (2*POS_BITS)'(dy_s2_r) * (2*POS_BITS)'(dy_s2_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      dx2_s3_r    <= dx_sq[SQ_BITS-1:0];
      dy2_s3_r    <= dy_sq[SQ_BITS-1:0];
      cand_s3_r   <= cand_s2_r;
      border_s3_r <= border_s2_r;
    end
  end

  // Stage 4: zone compare and colour choice into the output register.
  logic [SQ_BITS:0]   dist_sum;
  logic [SQ_BITS+2:0] dist4;
  logic               in_zone, edge_zone;
  logic               we_nxt;
  logic [COLOR_BITS-1:0] color_nxt;
  logic               we_r;
  logic [COLOR_BITS-1:0] color_r;

  assign dist_sum  = {1'b0, dx2_s3_r} + {1'b0, dy2_s3_r};
  assign dist4     = {dist_sum, 2'b00};
  assign in_zone   = in_ok_r && (dist4 <= {{(SQ_BITS+3-THR_BITS){1'b0}}, thr_in_r});
  assign edge_zone = out_ok_r && (dist4 <= {{(SQ_BITS+3-THR_BITS){1'b0}}, thr_out_r});

  always_comb begin
    we_nxt    = 1'b0;
    color_nxt = '0;
    if (cand_s3_r) begin
      case (kind_r)
        SHAPE_RECT: begin
          we_nxt    = 1'b1;
          color_nxt = border_s3_r ? edge_color_r : inside_color_r;
        end
        SHAPE_CIRCLE: begin
          if (in_zone) begin
            we_nxt    = 1'b1;
            color_nxt = inside_color_r;
          end else if (edge_zone) begin
            we_nxt    = 1'b1;
            color_nxt = edge_color_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      we_r    <= we_nxt;
      color_r <= color_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {{(OUT_BITS-COLOR_BITS-1){1'b0}}, color_r, we_r};

endmodule

[src/sspsh_checker.sv]
// Port-level checker for the scanline shape pixel shader, bound to the top level.
module sspsh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sspsh_pkg::OUT_BITS-1:0]  out_tdata
);
  import sspsh_pkg::*;

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid straight after reset");

  // When the output drains, every stage can move, so the input must be open.
  a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked although the output is being drained");

  // A pixel that is not written carries a zero colour.
  a_colour_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[COLOR_BITS:1] == '0)
    else $error("colour set on a pixel that is not written");

  // A stalled result word holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or vanished");

endmodule

bind scanline_shape_pixel_shader_core sspsh_checker u_sspsh_checker (.*);

[bench/tb_scanline_shape_pixel_shader_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the scanline shape pixel shader core.
module tb_scanline_shape_pixel_shader_core;
  import sspsh_pkg::*;

  localparam int LINE_COLUMNS     = 1024;
  localparam int HOLD_CYCLES      = 80;
  localparam int RANDOM_PHASES    = 24;
  localparam int PIXELS_PER_PHASE = 40;
  localparam int DRAIN_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 200000;
  localparam logic [KIND_BITS-1:0] SHAPE_UNUSED = 2'd3;

  typedef struct packed {
    logic                  write_enable;
    logic [COLOR_BITS-1:0] pixel_color;
  } pixel_result_t;

  class pixel_scoreboard;
    pixel_result_t         expected_pixels[$];
    logic [KIND_BITS-1:0]  kind_r;
    logic [COORD_BITS-1:0] left_r, top_r;
    logic [SIZE_BITS-1:0]  width_r, height_r;
    logic [THICK_BITS-1:0] thick_r;
    logic [COLOR_BITS-1:0] fill_r, border_r;
    int errors, accepted, painted, border_hits;

    function new();
      kind_r = SHAPE_NONE;
      left_r = '0;
      top_r = '0;
      width_r = '0;
      height_r = '0;
      thick_r = '0;
      fill_r = '0;
      border_r = '0;
      errors = 0;
      accepted = 0;
      painted = 0;
      border_hits = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [DATA_BITS-1:0] value);
      case (idx)
        REG_SHAPE_KIND:     kind_r = value[KIND_BITS-1:0];
        REG_BOX_LEFT:       left_r = value[COORD_BITS-1:0];
        REG_BOX_TOP:        top_r = value[COORD_BITS-1:0];
        REG_BOX_WIDTH:      width_r = value[SIZE_BITS-1:0];
        REG_BOX_HEIGHT:     height_r = value[SIZE_BITS-1:0];
        REG_EDGE_THICKNESS: thick_r = value[THICK_BITS-1:0];
        REG_INSIDE_COLOR:   fill_r = value[COLOR_BITS-1:0];
        REG_EDGE_COLOR:     border_r = value[COLOR_BITS-1:0];
        default: ;
      endcase
    endfunction

    function pixel_result_t shade_pixel(logic [IN_BITS-1:0] word);
      longint col, org, lim, row, left, top, w, h, t, x;
      longint rad, dx, dy, dist4, inner, outer;
      logic hit;
      pixel_result_t res;
      col = longint'(word[COLUMN_BITS-1:0]);
      org = longint'(word[2*COLUMN_BITS-1:COLUMN_BITS]);
      lim = longint'(word[3*COLUMN_BITS-1:2*COLUMN_BITS]);
      row = longint'($signed(word[3*COLUMN_BITS+COORD_BITS-1:3*COLUMN_BITS]));
      left = longint'($signed(left_r));
      top = longint'($signed(top_r));
      w = longint'(width_r);
      h = longint'(height_r);
      t = longint'(thick_r);
      x = col - org;
      res = '0;
      hit = col >= org && col <= lim && col < LINE_COLUMNS &&
            x >= left && x <= left + w && row >= top && row <= top + h;
      if (hit && kind_r == SHAPE_RECT) begin
        res.write_enable = 1'b1;
        if (x < left + t || x > left + w - t || row < top + t || row > top + h - t) begin
          res.pixel_color = border_r;
          border_hits++;
        end else begin
          res.pixel_color = fill_r;
        end
      end else if (hit && kind_r == SHAPE_CIRCLE) begin
        // Everything is doubled so that the half-pixel rounding stays exact.
        rad = (w / 2 < h / 2) ? w / 2 : h / 2;
        dx = x - (left + w / 2);
        dy = row - (top + h / 2);
        dist4 = 4 * (dx * dx + dy * dy);
        inner = 2 * (rad - t) - 1;
        outer = 2 * rad - 1;
        if (rad - t >= 1 && dist4 <= inner * inner) begin
          res.write_enable = 1'b1;
          res.pixel_color = fill_r;
        end else if (rad >= 1 && dist4 <= outer * outer) begin
          res.write_enable = 1'b1;
          res.pixel_color = border_r;
          border_hits++;
        end
      end
      return res;
    endfunction

    function void note_pixel(logic [IN_BITS-1:0] word);
      expected_pixels.push_back(shade_pixel(word));
      accepted++;
    endfunction

    function void check_result(logic [OUT_BITS-1:0] word);
      pixel_result_t want;
      if (expected_pixels.size() == 0) begin
        $error("result word %h arrived with no pixel outstanding", word);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (want.write_enable) painted++;
      if (word[0] !== want.write_enable) begin
        $error("write_enable: expected %0d, got %0d", want.write_enable, word[0]);
        errors++;
      end
      if (word[COLOR_BITS:1] !== want.pixel_color) begin
        $error("pixel_color: expected %h, got %h", want.pixel_color, word[COLOR_BITS:1]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_BITS-1:0]    in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_BITS-1:0]   out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  cfg_paddr = '0;
  logic [DATA_BITS-1:0]  cfg_pwdata = '0;
  logic [DATA_BITS-1:0]  cfg_prdata;
  logic                  cfg_pready;

  pixel_scoreboard sb = new();

  // Current box, kept here to aim random pixels at it.
  logic signed [COORD_BITS-1:0] left_s, top_s;
  logic [SIZE_BITS-1:0]        width_s, height_s;
  int  settings_count = 0;
  int  cycle_count = 0;
  logic no_gaps = 1'b0;
  logic hold_req = 1'b0;
  int  hold_left = 0;

  scanline_shape_pixel_shader_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_gaps || ($urandom_range(99) >= 17);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic [IN_BITS-1:0] pixel_word(int col, int org, int lim, int row);
    return {6'd0, COORD_BITS'(row), COLUMN_BITS'(lim), COLUMN_BITS'(org), COLUMN_BITS'(col)};
  endfunction

  // Aims at the current box with a margin of a few pixels on every side.
  function automatic logic [IN_BITS-1:0] near_box_pixel();
    int x, row, org, col, lim;
    x = int'(left_s) - 3 + int'($urandom_range(int'(width_s) + 6));
    if (x < 0) x = int'($urandom_range(20));
    if (x > LINE_COLUMNS - 1) x = LINE_COLUMNS - 1 - int'($urandom_range(20));
    org = $urandom_range(LINE_COLUMNS - 1 - x);
    col = org + x;
    lim = ($urandom_range(9) == 0) ? $urandom_range(LINE_COLUMNS - 1) :
                                     $urandom_range(LINE_COLUMNS - 1, col);
    row = int'(top_s) - 3 + int'($urandom_range(int'(height_s) + 6));
    if (row > 2047) row = 2047;
    if (row < -2048) row = -2048;
    return pixel_word(col, org, lim, row);
  endfunction

  // Called at a falling edge; leaves psel high so that writes can follow back to back.
  task automatic write_register(input logic [2:0] idx, input logic [DATA_BITS-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [KIND_BITS-1:0] kind, input int left, input int top,
                                input int w, input int h, input int t,
                                input logic [COLOR_BITS-1:0] fill,
                                input logic [COLOR_BITS-1:0] border);
    left_s = COORD_BITS'(left);
    top_s = COORD_BITS'(top);
    width_s = SIZE_BITS'(w);
    height_s = SIZE_BITS'(h);
    write_register(REG_SHAPE_KIND, DATA_BITS'(kind));
    write_register(REG_BOX_LEFT, DATA_BITS'(left_s));
    write_register(REG_BOX_TOP, DATA_BITS'(top_s));
    write_register(REG_BOX_WIDTH, DATA_BITS'(width_s));
    write_register(REG_BOX_HEIGHT, DATA_BITS'(height_s));
    write_register(REG_EDGE_THICKNESS, DATA_BITS'(THICK_BITS'(t)));
    write_register(REG_INSIDE_COLOR, DATA_BITS'(fill));
    write_register(REG_EDGE_COLOR, DATA_BITS'(border));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    settings_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_pixel(input logic [IN_BITS-1:0] word);
    if (!no_gaps) begin
      while ($urandom_range(99) < 17) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int phase, n, pick, w, h, t;
    logic [KIND_BITS-1:0] kind;
    logic [IN_BITS-1:0] word;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers straight out of reset draw nothing.
    send_pixel(pixel_word(0, 0, 0, 0));
    drain();

    // Rectangle: corners, inside, every side just outside, and window clipping.
    apply_settings(SHAPE_RECT, 5, 10, 20, 8, 2, 16'h1234, 16'hffff);
    send_pixel(pixel_word(105, 100, 1023, 10));
    send_pixel(pixel_word(107, 100, 1023, 12));
    send_pixel(pixel_word(125, 100, 1023, 18));
    send_pixel(pixel_word(104, 100, 1023, 12));
    send_pixel(pixel_word(126, 100, 1023, 12));
    send_pixel(pixel_word(110, 100, 1023, 9));
    send_pixel(pixel_word(110, 100, 1023, 19));
    send_pixel(pixel_word(105, 100, 104, 12));
    send_pixel(pixel_word(110, 100, 50, 12));
    send_pixel(pixel_word(99, 100, 1023, 12));
    drain();

    // Zero thickness leaves no border; full thickness leaves no inside.
    apply_settings(SHAPE_RECT, 5, 10, 20, 8, 0, 16'h1234, 16'hffff);
    send_pixel(pixel_word(105, 100, 1023, 10));
    drain();
    apply_settings(SHAPE_RECT, 5, 10, 20, 8, 255, 16'h1234, 16'hffff);
    send_pixel(pixel_word(115, 100, 1023, 14));
    drain();

    // Circle of radius ten: centre, ring, box corner, just past the ring.
    apply_settings(SHAPE_CIRCLE, 0, 0, 20, 30, 3, 16'h00ff, 16'hff00);
    send_pixel(pixel_word(10, 0, 1023, 15));
    send_pixel(pixel_word(10, 0, 1023, 6));
    send_pixel(pixel_word(0, 0, 1023, 0));
    send_pixel(pixel_word(10, 0, 1023, 5));
    drain();
    apply_settings(SHAPE_CIRCLE, 0, 0, 20, 30, 255, 16'h00ff, 16'hff00);
    send_pixel(pixel_word(10, 0, 1023, 15));
    drain();
    apply_settings(SHAPE_UNUSED, 0, 0, 20, 30, 3, 16'h00ff, 16'hff00);
    send_pixel(pixel_word(10, 0, 1023, 15));
    drain();

    // Largest box reaching the lowest row, with the extreme column values.
    apply_settings(SHAPE_RECT, 0, -2048, 2047, 2047, 1, 16'hffff, 16'h0000);
    send_pixel(pixel_word(1023, 0, 1023, -2048));
    send_pixel(pixel_word(1023, 0, 1023, -1000));
    send_pixel(pixel_word(1023, 0, 1023, 2047));
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(9);
      kind = (pick < 4) ? SHAPE_RECT : (pick < 8) ? SHAPE_CIRCLE :
             (pick == 8) ? SHAPE_NONE : SHAPE_UNUSED;
      w = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(60);
      h = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(60);
      t = ($urandom_range(5) == 0) ? $urandom_range(255) : $urandom_range(12);
      if ($urandom_range(7) == 0) begin
        apply_settings(kind, int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                       w, h, t, 16'($urandom), 16'($urandom));
      end else begin
        apply_settings(kind, int'($urandom_range(640)) - 40, int'($urandom_range(400)) - 200,
                       w, h, t, 16'($urandom), 16'($urandom));
      end
      no_gaps = (phase == 5);
      for (n = 0; n < PIXELS_PER_PHASE; n++) begin
        // Stall the result side for a long while so that the pipeline backs up.
        if (phase == 2 && n == 8) hold_req = 1'b1;
        if ($urandom_range(4) == 0) begin
          word = {6'd0, COORD_BITS'($urandom), COLUMN_BITS'($urandom),
                  COLUMN_BITS'($urandom), COLUMN_BITS'($urandom)};
        end else begin
          word = near_box_pixel();
        end
        send_pixel(word);
      end
      no_gaps = 1'b0;
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Shaded %0d pixels under %0d register settings: %0d painted, %0d of them border.",
             sb.accepted, settings_count, sb.painted, sb.border_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sspsh_pkg.sv
src/scanline_shape_pixel_shader_core.sv
src/sspsh_checker.sv
bench/tb_scanline_shape_pixel_shader_core.sv
